### hw/rtl/rae_pkg.sv
package rae_pkg;

  localparam int VALUE_FRAC_BITS = 16;
  localparam logic signed [31:0] ESC_THRESH = 32'sd2 <<< VALUE_FRAC_BITS;

  localparam logic [1:0] OPC_LOAD  = 2'd0;
  localparam logic [1:0] OPC_EVAL  = 2'd1;
  localparam logic [1:0] OPC_CLEAR = 2'd2;

  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_EVAL,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [3:0]         idx;
    logic               kind;
    logic               above;
    logic               level;
    logic               enabled;
    logic               escalate;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic               above;
    logic signed [31:0] threshold;
    logic               level;
    logic               escalate;
  } rule_t;

  typedef enum logic {
    BK_RUN,
    BK_SCAN
  } back_state_t;

endpackage

### hw/rtl/rule_alarm_evaluator.sv
// Rule alarm evaluator. Items enter on start when busy is low; results leave
// as one-cycle beats marked by out_valid and cannot be held off. Load and
// evaluate items run at one item per cycle while busy is low, passing an input
// register, a two-entry command queue and the back end's output registers. A
// clear-all item holds the back end while it scans each rule index from 0 up to
// the highest active rule, giving one beat per active rule; busy rises once the
// queue fills behind it.
module rule_alarm_evaluator #(
  parameter int RULE_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_rule_index,
  input  logic               in_rule_kind,
  input  logic               in_above,
  input  logic signed [31:0] in_threshold,
  input  logic               in_base_level,
  input  logic               in_enabled,
  input  logic               in_escalate,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_sample_valid,
  output logic               out_valid,
  output logic [3:0]         out_alarm_rule,
  output logic               out_raised,
  output logic               out_alarm_level,
  output logic signed [31:0] out_reported_value,
  output logic               out_last_of_run
);
  import rae_pkg::*;

  cmd_t front_cmd, q_cmd;
  logic front_vld, q_rdy, q_vld, q_pop;

  rae_front #(.RULE_COUNT(RULE_COUNT)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_rule_index   (in_rule_index),
    .in_rule_kind    (in_rule_kind),
    .in_above        (in_above),
    .in_threshold    (in_threshold),
    .in_base_level   (in_base_level),
    .in_enabled      (in_enabled),
    .in_escalate     (in_escalate),
    .in_sample_value (in_sample_value),
    .in_sample_valid (in_sample_valid),
    .cmd_o           (front_cmd),
    .cmd_vld_o       (front_vld),
    .cmd_rdy_i       (q_rdy)
  );

  rae_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_data (front_cmd),
    .push      (front_vld),
    .push_rdy  (q_rdy),
    .pop_data  (q_cmd),
    .pop_vld   (q_vld),
    .pop       (q_pop)
  );

  rae_back #(.RULE_COUNT(RULE_COUNT)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (q_cmd),
    .cmd_vld_i          (q_vld),
    .cmd_pop_o          (q_pop),
    .out_valid          (out_valid),
    .out_alarm_rule     (out_alarm_rule),
    .out_raised         (out_raised),
    .out_alarm_level    (out_alarm_level),
    .out_reported_value (out_reported_value),
    .out_last_of_run    (out_last_of_run)
  );

endmodule

### hw/rtl/rae_front.sv
module rae_front #(
  parameter int RULE_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [3:0]         in_rule_index,
  input  logic               in_rule_kind,
  input  logic               in_above,
  input  logic signed [31:0] in_threshold,
  input  logic               in_base_level,
  input  logic               in_enabled,
  input  logic               in_escalate,
  input  logic signed [31:0] in_sample_value,
  input  logic               in_sample_valid,
  output rae_pkg::cmd_t      cmd_o,
  output logic               cmd_vld_o,
  input  logic               cmd_rdy_i
);
  import rae_pkg::*;

  logic vld_r, vld_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take, keep, in_range;

  assign busy     = vld_r & ~cmd_rdy_i;
  assign take     = start & ~busy;
  assign in_range = int'(in_rule_index) < RULE_COUNT;

  // classify: out-of-range, skipped and unknown beats are dropped here
  always_comb begin
    cmd_nxt.idx      = in_rule_index;
    cmd_nxt.kind     = in_rule_kind;
    cmd_nxt.above    = in_above;
    cmd_nxt.level    = in_base_level;
    cmd_nxt.enabled  = in_enabled;
    cmd_nxt.escalate = in_escalate;
    cmd_nxt.value    = in_sample_value;
    cmd_nxt.op       = CMD_LOAD;
    keep             = 1'b0;
    unique case (in_opcode)
      OPC_LOAD: begin
        cmd_nxt.op    = CMD_LOAD;
        cmd_nxt.value = in_threshold;
        keep          = in_range;
      end
      OPC_EVAL: begin
        cmd_nxt.op = CMD_EVAL;
        keep       = in_range & in_sample_valid;
      end
      OPC_CLEAR: begin
        cmd_nxt.op = CMD_CLEAR;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign vld_nxt = take ? keep : (vld_r & ~cmd_rdy_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_o     = cmd_r;
  assign cmd_vld_o = vld_r;

endmodule

### hw/rtl/rae_cmdq.sv
module rae_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  rae_pkg::cmd_t push_data,
  input  logic          push,
  output logic          push_rdy,
  output rae_pkg::cmd_t pop_data,
  output logic          pop_vld,
  input  logic          pop
);
  import rae_pkg::*;

  localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          mem_r [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_rdy = count_r != CW'(CMDQ_DEPTH);
  assign pop_vld  = count_r != '0;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push & push_rdy;
  assign do_pop   = pop & pop_vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CMDQ_DEPTH)) else $error("command queue count out of range");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_vld) else $error("command queue underflow");

endmodule

### hw/rtl/rae_back.sv
module rae_back #(
  parameter int RULE_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rae_pkg::cmd_t      cmd_i,
  input  logic               cmd_vld_i,
  output logic               cmd_pop_o,
  output logic               out_valid,
  output logic [3:0]         out_alarm_rule,
  output logic               out_raised,
  output logic               out_alarm_level,
  output logic signed [31:0] out_reported_value,
  output logic               out_last_of_run
);
  import rae_pkg::*;

  // a 4-bit index reaches at most 16 rules
  localparam int DEPTH = (RULE_COUNT < 16) ? RULE_COUNT : 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rule_t              rules_r [DEPTH];
  logic [DEPTH-1:0]   en_r, en_nxt, flags_r, flags_nxt, rest;
  back_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   scan_r, scan_nxt, idx;
  rule_t              entry;
  logic               hit, lvl, wr_en;

  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_rule_r, out_rule_nxt;
  logic               out_raised_r, out_raised_nxt;
  logic               out_level_r, out_level_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic               out_last_r, out_last_nxt;

  assign idx       = cmd_i.idx[IDX_W-1:0];
  assign entry     = rules_r[idx];
  assign cmd_pop_o = (state_r == BK_RUN) & cmd_vld_i;
  assign rest      = flags_r & ~(DEPTH'(1) << scan_r);

  always_comb begin
    if (entry.kind) begin
      hit = entry.above ? ($signed(cmd_i.value) > $signed(entry.threshold))
                        : ($signed(cmd_i.value) < $signed(entry.threshold));
    end else begin
      hit = cmd_i.value != '0;
    end
    lvl = entry.level |
          (~entry.kind & entry.escalate & ($signed(cmd_i.value) >= ESC_THRESH));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_RUN: begin
        if (cmd_pop_o && cmd_i.op == CMD_CLEAR && flags_r != '0) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (rest == '0) begin
          state_nxt = BK_RUN;
        end
      end
      default: begin
        state_nxt = BK_RUN;
      end
    endcase
  end

  always_comb begin
    en_nxt         = en_r;
    flags_nxt      = flags_r;
    scan_nxt       = scan_r;
    wr_en          = 1'b0;
    out_valid_nxt  = 1'b0;
    out_rule_nxt   = cmd_i.idx;
    out_raised_nxt = 1'b0;
    out_level_nxt  = 1'b0;
    out_value_nxt  = cmd_i.value;
    out_last_nxt   = 1'b1;
    unique case (state_r)
      BK_RUN: begin
        if (cmd_pop_o) begin
          unique case (cmd_i.op)
            CMD_LOAD: begin
              wr_en       = 1'b1;
              en_nxt[idx] = cmd_i.enabled;
            end
            CMD_EVAL: begin
              if (en_r[idx]) begin
                if (hit && !flags_r[idx]) begin
                  flags_nxt[idx] = 1'b1;
                  out_valid_nxt  = 1'b1;
                  out_raised_nxt = 1'b1;
                  out_level_nxt  = lvl;
                end else if (!hit && flags_r[idx]) begin
                  flags_nxt[idx] = 1'b0;
                  out_valid_nxt  = 1'b1;
                end
              end
            end
            CMD_CLEAR: begin
              scan_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      BK_SCAN: begin
        // flags below scan_r are already clear
        scan_nxt      = scan_r + IDX_W'(1);
        flags_nxt     = rest;
        out_valid_nxt = flags_r[scan_r];
        out_rule_nxt  = 4'(scan_r);
        out_value_nxt = '0;
        out_last_nxt  = rest == '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_RUN;
      en_r        <= '0;
      flags_r     <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      flags_r     <= flags_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rule_r   <= out_rule_nxt;
    out_raised_r <= out_raised_nxt;
    out_level_r  <= out_level_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rules_r[idx] <= '{kind: cmd_i.kind, above: cmd_i.above, threshold: cmd_i.value,
                        level: cmd_i.level, escalate: cmd_i.escalate};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_alarm_rule     = out_rule_r;
  assign out_raised         = out_raised_r;
  assign out_alarm_level    = out_level_r;
  assign out_reported_value = out_value_r;
  assign out_last_of_run    = out_last_r;

  a_scan_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_SCAN |-> flags_r != '0) else $error("scan with no active flag");

  a_clear_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_raised_r |-> !out_level_r) else $error("clear beat has level");

  a_raise_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_raised_r |-> out_last_r) else $error("raise not last of run");

endmodule

### dv/rule_alarm_evaluator_tb.sv
`timescale 1ns / 100ps

module rule_alarm_evaluator_tb;
  import rae_pkg::*;

  localparam logic [1:0] OPC_NONE = 2'd3;
  localparam int NUM_RULES = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]         opcode;
    logic [3:0]         idx;
    logic               kind;
    logic               above;
    logic signed [31:0] threshold;
    logic               base_level;
    logic               enabled;
    logic               escalate;
    logic signed [31:0] sample;
    logic               sample_valid;
  } alarm_cmd_t;

  typedef struct {
    logic               kind;
    logic               above;
    logic signed [31:0] threshold;
    logic               level;
    logic               enabled;
    logic               escalate;
  } rule_entry_t;

  typedef struct {
    logic [3:0]         rule;
    logic               raised;
    logic               level;
    logic signed [31:0] value;
    logic               last;
  } alarm_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_opcode = '0;
  logic [3:0]         in_rule_index = '0;
  logic               in_rule_kind = 1'b0;
  logic               in_above = 1'b0;
  logic signed [31:0] in_threshold = '0;
  logic               in_base_level = 1'b0;
  logic               in_enabled = 1'b0;
  logic               in_escalate = 1'b0;
  logic signed [31:0] in_sample_value = '0;
  logic               in_sample_valid = 1'b0;
  logic               out_valid;
  logic [3:0]         out_alarm_rule;
  logic               out_raised;
  logic               out_alarm_level;
  logic signed [31:0] out_reported_value;
  logic               out_last_of_run;

  rule_entry_t rule_tbl [NUM_RULES];
  logic [NUM_RULES-1:0] active_flags;
  alarm_beat_t alarm_q [$];
  int err_cnt = 0;
  int cycle_cnt = 0;
  bit idle_on = 1'b1;

  rule_alarm_evaluator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_rule_index     (in_rule_index),
    .in_rule_kind      (in_rule_kind),
    .in_above          (in_above),
    .in_threshold      (in_threshold),
    .in_base_level     (in_base_level),
    .in_enabled        (in_enabled),
    .in_escalate       (in_escalate),
    .in_sample_value   (in_sample_value),
    .in_sample_valid   (in_sample_valid),
    .out_valid         (out_valid),
    .out_alarm_rule    (out_alarm_rule),
    .out_raised        (out_raised),
    .out_alarm_level   (out_alarm_level),
    .out_reported_value(out_reported_value),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, alarm_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic void queue_beat(input alarm_beat_t b);
    alarm_q = {alarm_q, b};
  endfunction

  // Alarm predictor: latched flag per rule, raise/clear on edges of the hit.
  function automatic void predict_alarms(input alarm_cmd_t c);
    alarm_beat_t b;
    logic hit;
    int n;
    n = 0;
    case (c.opcode)
      OPC_LOAD: begin
        rule_tbl[c.idx] = '{c.kind, c.above, c.threshold, c.base_level, c.enabled,
                            c.escalate};
      end
      OPC_EVAL: begin
        if (rule_tbl[c.idx].enabled && c.sample_valid) begin
          if (rule_tbl[c.idx].kind)
            hit = rule_tbl[c.idx].above ? (c.sample > rule_tbl[c.idx].threshold)
                                        : (c.sample < rule_tbl[c.idx].threshold);
          else
            hit = (c.sample != 0);
          b.rule = c.idx;
          b.value = c.sample;
          b.last = 1'b1;
          if (hit && !active_flags[c.idx]) begin
            b.raised = 1'b1;
            b.level = rule_tbl[c.idx].level;
            if (!rule_tbl[c.idx].kind && rule_tbl[c.idx].escalate && c.sample >= ESC_THRESH)
              b.level = 1'b1;
            active_flags[c.idx] = 1'b1;
            queue_beat(b);
          end else if (!hit && active_flags[c.idx]) begin
            b.raised = 1'b0;
            b.level = 1'b0;
            active_flags[c.idx] = 1'b0;
            queue_beat(b);
          end
        end
      end
      OPC_CLEAR: begin
        for (int i = 0; i < NUM_RULES; i++) begin
          if (active_flags[i]) begin
            b = '{rule: i[3:0], raised: 1'b0, level: 1'b0, value: '0, last: 1'b0};
            queue_beat(b);
            n++;
          end
        end
        if (n > 0) begin
          alarm_q[alarm_q.size() - 1].last = 1'b1;
        end
        active_flags = '0;
      end
      default: ;
    endcase
  endfunction

  // Result beats cannot be held off: check every strobe against the oldest expectation.
  always @(posedge clk) begin : beat_check
    alarm_beat_t exp_b;
    if (rst_n && out_valid) begin
      if (alarm_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat rule=%0d raised=%0b", out_alarm_rule,
                                  out_raised));
      end else begin
        exp_b = alarm_q.pop_front();
        if (out_alarm_rule !== exp_b.rule)
          report_mismatch($sformatf("alarm_rule %0d, want %0d", out_alarm_rule, exp_b.rule));
        if (out_raised !== exp_b.raised)
          report_mismatch($sformatf("raised %0b, want %0b (rule %0d)", out_raised,
                                    exp_b.raised, exp_b.rule));
        if (out_alarm_level !== exp_b.level)
          report_mismatch($sformatf("alarm_level %0b, want %0b (rule %0d)", out_alarm_level,
                                    exp_b.level, exp_b.rule));
        if (out_reported_value !== exp_b.value)
          report_mismatch($sformatf("reported_value %h, want %h (rule %0d)",
                                    out_reported_value, exp_b.value, exp_b.rule));
        if (out_last_of_run !== exp_b.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b (rule %0d)", out_last_of_run,
                                    exp_b.last, exp_b.rule));
      end
    end
  end

  task automatic send_cmd(input alarm_cmd_t c);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= c.opcode;
    in_rule_index   <= c.idx;
    in_rule_kind    <= c.kind;
    in_above        <= c.above;
    in_threshold    <= c.threshold;
    in_base_level   <= c.base_level;
    in_enabled      <= c.enabled;
    in_escalate     <= c.escalate;
    in_sample_value <= c.sample;
    in_sample_valid <= c.sample_valid;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_alarms(c);
  endtask

  function automatic alarm_cmd_t mk_load(input logic [3:0] idx, input logic kind,
                                         input logic above, input logic signed [31:0] thr,
                                         input logic lvl, input logic en, input logic esc);
    alarm_cmd_t c;
    c = '{OPC_LOAD, idx, kind, above, thr, lvl, en, esc, '0, 1'b0};
    return c;
  endfunction

  function automatic alarm_cmd_t mk_eval(input logic [3:0] idx, input logic signed [31:0] val,
                                         input logic vld);
    alarm_cmd_t c;
    c = '{OPC_EVAL, idx, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, val, vld};
    return c;
  endfunction

  function automatic alarm_cmd_t mk_op(input logic [1:0] opc);
    alarm_cmd_t c;
    c = '{opc, 4'd0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0, '0, 1'b0};
    return c;
  endfunction

  // Mostly loads and evaluations with samples near the rule's threshold and the 2.0 mark.
  function automatic alarm_cmd_t random_cmd();
    alarm_cmd_t c;
    int sel;
    logic signed [31:0] thr;
    c.idx = 4'($urandom);
    c.kind = 1'($urandom);
    c.above = 1'($urandom);
    c.threshold = $urandom;
    c.base_level = 1'($urandom);
    c.enabled = ($urandom_range(0, 6) != 0);
    c.escalate = 1'($urandom);
    c.sample = $urandom;
    c.sample_valid = ($urandom_range(0, 9) != 0);
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      c.opcode = OPC_LOAD;
      case ($urandom_range(0, 4))
        0: c.threshold = 32'sh7fffffff;
        1: c.threshold = 32'sh80000000;
        2, 3: c.threshold = $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
        default: ;
      endcase
    end else if (sel < 92) begin
      c.opcode = OPC_EVAL;
      thr = rule_tbl[c.idx].threshold;
      case ($urandom_range(0, 9))
        0, 1: c.sample = '0;
        2: c.sample = thr;
        3: c.sample = thr + 1;
        4: c.sample = thr - 1;
        5: c.sample = ESC_THRESH;
        6: c.sample = ESC_THRESH - 1;
        7: c.sample = $signed($urandom_range(0, 32'h60000)) - 32'sh30000;
        8: c.sample = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        default: ;
      endcase
    end else if (sel < 97) begin
      c.opcode = OPC_CLEAR;
    end else begin
      c.opcode = OPC_NONE;
    end
    return c;
  endfunction

  task automatic test_fault_rules();
    send_cmd(mk_load(4'd0, 1'b0, 1'b0, '0, 1'b0, 1'b1, 1'b1));
    send_cmd(mk_eval(4'd0, ESC_THRESH, 1'b1));
    send_cmd(mk_eval(4'd0, 32'sd5, 1'b1));
    send_cmd(mk_eval(4'd0, '0, 1'b1));
    send_cmd(mk_eval(4'd0, ESC_THRESH - 1, 1'b1));
    send_cmd(mk_eval(4'd0, '0, 1'b0));
    send_cmd(mk_eval(4'd0, '0, 1'b1));
  endtask

  task automatic test_threshold_rules();
    send_cmd(mk_load(4'd15, 1'b1, 1'b1, 32'sh7fffffff, 1'b1, 1'b1, 1'b0));
    send_cmd(mk_eval(4'd15, 32'sh7fffffff, 1'b1));
    send_cmd(mk_load(4'd15, 1'b1, 1'b1, 32'sh80000000, 1'b0, 1'b1, 1'b1));
    send_cmd(mk_eval(4'd15, 32'sh7fffffff, 1'b1));
    // reload while active: flag is kept
    send_cmd(mk_load(4'd15, 1'b1, 1'b0, 32'sh80000000, 1'b0, 1'b1, 1'b0));
    send_cmd(mk_eval(4'd15, 32'sh80000000, 1'b1));
    send_cmd(mk_load(4'd7, 1'b1, 1'b0, '0, 1'b1, 1'b1, 1'b0));
    send_cmd(mk_eval(4'd7, -32'sd1, 1'b1));
    send_cmd(mk_load(4'd7, 1'b1, 1'b0, '0, 1'b1, 1'b0, 1'b0));
    send_cmd(mk_eval(4'd7, '0, 1'b1));
  endtask

  task automatic test_clear_all();
    send_cmd(mk_load(4'd3, 1'b0, 1'b0, '0, 1'b0, 1'b1, 1'b0));
    send_cmd(mk_eval(4'd3, 32'sh80000000, 1'b1));
    send_cmd(mk_load(4'd15, 1'b0, 1'b0, '0, 1'b0, 1'b1, 1'b1));
    send_cmd(mk_eval(4'd15, 32'sh7fffffff, 1'b1));
    send_cmd(mk_op(OPC_CLEAR));
    send_cmd(mk_op(OPC_CLEAR));
    send_cmd(mk_op(OPC_NONE));
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 260; i++) begin
      if (i % 40 == 0)
        idle_on = ((i / 40) % 3 != 2);
      send_cmd(random_cmd());
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    for (int i = 0; i < 40; i++)
      send_cmd(random_cmd());
  endtask

  initial begin
    for (int i = 0; i < NUM_RULES; i++)
      rule_tbl[i] = '{1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0};
    active_flags = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fault_rules();
    test_threshold_rules();
    test_clear_all();
    test_random_traffic();
    test_back_to_back();
    start <= 1'b0;
    while (alarm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/rae_pkg.sv
hw/rtl/rae_front.sv
hw/rtl/rae_cmdq.sv
hw/rtl/rae_back.sv
hw/rtl/rule_alarm_evaluator.sv
dv/rule_alarm_evaluator_tb.sv
